@@ rtl/htd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Huffman tree decoder package
// Widths, codes and shared types for the node-table tree-walk decoder.
// ----------------------------------------------------------------------------
package htd_pkg;

  // Field widths
  localparam int IDX_W = 9;
  localparam int SYM_W = 8;
  localparam int OP_W  = 2;
  localparam int ST_W  = 2;

  // Node table spans every index the child fields can name
  localparam int NODE_COUNT = 1 << IDX_W;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Opcodes of an input item
  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_DECODE = 2'd1;
  localparam logic [OP_W-1:0] OP_END    = 2'd2;

  // Result status codes
  localparam logic [ST_W-1:0] ST_SYMBOL    = 2'd0;
  localparam logic [ST_W-1:0] ST_END_CLEAN = 2'd1;
  localparam logic [ST_W-1:0] ST_END_TRUNC = 2'd2;

  // Register map
  localparam logic [1:0] ADDR_ROOT = 2'd0;

  // One node table entry
  typedef struct packed {
    logic             leaf;
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
    logic [SYM_W-1:0] sym;
  } node_t;

  // One queued command
  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic [IDX_W-1:0] node_index;
    node_t            node;
    logic             code_bit;
  } cmd_t;

  // Head of the command queue as seen by the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_head_t;

endpackage

@@ rtl/htd_ifs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Huffman tree decoder channel interfaces
// Valid/ready channels for input items and for decoded results.
// ----------------------------------------------------------------------------
interface htd_item_if import htd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  opcode;
  logic [IDX_W-1:0] node_index;
  logic             leaf_flag;
  logic [IDX_W-1:0] left_child;
  logic [IDX_W-1:0] right_child;
  logic [SYM_W-1:0] leaf_symbol;
  logic             code_bit;

  modport source (
    output valid, opcode, node_index, leaf_flag, left_child, right_child,
           leaf_symbol, code_bit,
    input  ready
  );
  modport sink (
    input  valid, opcode, node_index, leaf_flag, left_child, right_child,
           leaf_symbol, code_bit,
    output ready
  );
endinterface

interface htd_result_if import htd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic [ST_W-1:0]  status;

  modport source (output valid, symbol, status, input ready);
  modport sink   (input valid, symbol, status, output ready);
endinterface

@@ rtl/htd_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Huffman tree decoder front end
// Accepts input items, drops unused opcodes and queues the rest as commands.
// ----------------------------------------------------------------------------
module htd_front import htd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  htd_item_if.sink   items,
  output cmd_head_t  head,
  input  logic       pop
);

  cmd_t              fifo [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              take;
  logic              keep;
  cmd_t              cmd_in;

  // Accept whenever a queue slot is free
  assign items.ready = (count != (QPTR_W+1)'(QUEUE_DEPTH));
  assign take        = items.valid && items.ready;

  // Classify: only load, decode and end-of-stream items do anything
  always_comb begin
    keep = 1'b0;
    unique case (items.opcode)
      OP_LOAD, OP_DECODE, OP_END: keep = take;
      default:                    keep = 1'b0;
    endcase
  end

  // Pack the transfer into a command
  always_comb begin
    cmd_in.opcode     = items.opcode;
    cmd_in.node_index = items.node_index;
    cmd_in.node.leaf  = items.leaf_flag;
    cmd_in.node.left  = items.left_child;
    cmd_in.node.right = items.right_child;
    cmd_in.node.sym   = items.leaf_symbol;
    cmd_in.code_bit   = items.code_bit;
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (keep) begin
      fifo[wr_ptr] <= cmd_in;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (keep) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (keep && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !keep) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head.valid = (count != '0);
  assign head.cmd   = fifo[rd_ptr];

  // Back end never pops an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("pop from empty command queue");

  // Fill count never passes the depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QPTR_W+1)'(QUEUE_DEPTH))
    else $error("command queue overflow");

  // A kept transfer with no pop grows the queue by one
  a_count_grow: assert property (@(posedge clk) disable iff (rst)
    (keep && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not advance on push");

endmodule

@@ rtl/htd_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Huffman tree decoder back end
// Owns the node table and walks the tree one code bit per decode command.
// ----------------------------------------------------------------------------
module htd_back import htd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cmd_head_t         head,
  output logic              pop,
  input  logic [IDX_W-1:0]  root,
  htd_result_if.source      results
);

  localparam logic [1:0] S_POP  = 2'd0;
  localparam logic [1:0] S_ROOT = 2'd1;
  localparam logic [1:0] S_NEXT = 2'd2;

  // Node table
  node_t            mem [NODE_COUNT];
  logic             wr_en;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  node_t            rd_data;

  // Walk state
  logic [1:0]       state, state_next;
  logic             walking, walking_next;
  logic [IDX_W-1:0] cur_node, cur_node_next;
  node_t            cur_entry, cur_entry_next;
  logic [IDX_W-1:0] next_node, next_node_next;

  // Result register
  logic             out_valid;
  logic [SYM_W-1:0] out_symbol;
  logic [ST_W-1:0]  out_status;
  logic             can_emit;
  logic             emit;
  logic [SYM_W-1:0] emit_sym;
  logic [ST_W-1:0]  emit_status;

  cmd_t             cmd;
  node_t            here;
  logic [IDX_W-1:0] child;

  assign cmd      = head.cmd;
  assign can_emit = !out_valid || results.ready;

  // Node being left by this bit: cached current node mid-code, else the root read
  assign here  = (state == S_ROOT) ? rd_data : cur_entry;
  assign child = cmd.code_bit ? here.right : here.left;

  // Walk sequencer
  always_comb begin
    state_next     = state;
    walking_next   = walking;
    cur_node_next  = cur_node;
    cur_entry_next = cur_entry;
    next_node_next = next_node;
    rd_en          = 1'b0;
    rd_addr        = child;
    wr_en          = 1'b0;
    emit           = 1'b0;
    emit_sym       = '0;
    emit_status    = ST_SYMBOL;
    pop            = 1'b0;
    unique case (state)
      S_POP: begin
        if (head.valid) begin
          unique case (cmd.opcode)
            OP_LOAD: begin
              wr_en = 1'b1;
              pop   = 1'b1;
              // keep the cached current node coherent with the table
              if (walking && (cmd.node_index == cur_node)) begin
                cur_entry_next = cmd.node;
              end
            end
            OP_END: begin
              if (can_emit) begin
                emit         = 1'b1;
                emit_status  = walking ? ST_END_TRUNC : ST_END_CLEAN;
                walking_next = 1'b0;
                pop          = 1'b1;
              end
            end
            OP_DECODE: begin
              if (walking) begin
                if (cur_entry.leaf) begin
                  if (can_emit) begin
                    emit         = 1'b1;
                    emit_sym     = cur_entry.sym;
                    walking_next = 1'b0;
                    pop          = 1'b1;
                  end
                end else begin
                  rd_en          = 1'b1;
                  next_node_next = child;
                  state_next     = S_NEXT;
                end
              end else begin
                rd_en      = 1'b1;
                rd_addr    = root;
                state_next = S_ROOT;
              end
            end
            default: begin
              pop = 1'b1;
            end
          endcase
        end
      end
      S_ROOT: begin
        if (rd_data.leaf) begin
          // root is a leaf: emit it without moving
          if (can_emit) begin
            emit       = 1'b1;
            emit_sym   = rd_data.sym;
            pop        = 1'b1;
            state_next = S_POP;
          end
        end else begin
          rd_en          = 1'b1;
          next_node_next = child;
          state_next     = S_NEXT;
        end
      end
      S_NEXT: begin
        if (rd_data.leaf) begin
          if (can_emit) begin
            emit         = 1'b1;
            emit_sym     = rd_data.sym;
            walking_next = 1'b0;
            pop          = 1'b1;
            state_next   = S_POP;
          end
        end else begin
          walking_next   = 1'b1;
          cur_node_next  = next_node;
          cur_entry_next = rd_data;
          pop            = 1'b1;
          state_next     = S_POP;
        end
      end
      default: begin
        state_next = S_POP;
      end
    endcase
  end

  // Node table write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cmd.node_index] <= cmd.node;
    end
  end

  // Node table read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_POP;
      walking <= 1'b0;
    end else begin
      state   <= state_next;
      walking <= walking_next;
    end
  end

  // Walk payload
  always_ff @(posedge clk) begin
    cur_node  <= cur_node_next;
    cur_entry <= cur_entry_next;
    next_node <= next_node_next;
  end

  // Result register: load on emit, drop on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_symbol <= emit_sym;
      out_status <= emit_status;
    end
  end

  assign results.valid  = out_valid;
  assign results.symbol = out_symbol;
  assign results.status = out_status;

  // A command stays at the queue head while its reads are in flight
  a_head_held: assert property (@(posedge clk) disable iff (rst)
    (state != S_POP) |-> head.valid)
    else $error("command left the queue mid-walk");

  // A new result never overwrites one still waiting
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    emit |-> (!out_valid || results.ready))
    else $error("result overwritten before transfer");

  // A code is only entered from the child-read step
  a_walk_entry: assert property (@(posedge clk) disable iff (rst)
    $rose(walking) |-> ($past(state) == S_NEXT))
    else $error("walk started outside child read");

  // Table writes happen only in the pop state, never while a table read is in flight
  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_POP))
    else $error("node table written mid-walk");

endmodule

@@ rtl/huffman_tree_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Huffman tree decoder
// Bit-serial tree-walk decoder over a loaded node table, with an APB root
// register.
// ----------------------------------------------------------------------------
// Load items fill the 512-entry node table, decode items each carry one code
// bit, and end-of-stream items report a clean or truncated end. Items land in
// a four-entry command queue and are taken by the walker, which owns the node
// table as a synchronous memory with one write port and one registered read
// port, which sets the pace. A bit in the middle of a code reads the child,
// then decides, or decides at once when a load has turned the current node
// into a leaf; the first bit of a code reads the root, then the child, then
// decides, or decides on the root read when the root is itself a leaf; load
// and end-of-stream items need no read. Results leave through an output
// register, so the walker carries on with work that yields no result while a
// result waits for its transfer, and stalls only when it has a second one to
// hand over. Reading a never-loaded table entry gives undefined symbols. The
// user must write the root register only while the block is idle; the block
// does not enforce this. A change of root takes effect from the next code.
module huffman_tree_decoder import htd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  htd_item_if.sink          items,
  htd_result_if.source      results,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [1:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [IDX_W-1:0] root_node;
  cmd_head_t        head;
  logic             pop;

  // APB register access
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      root_node <= '0;
    end else if (psel && penable && pwrite) begin
      root_node <= pwdata[IDX_W-1:0];
    end
  end

  assign prdata = (paddr == ADDR_ROOT) ? {{(32-IDX_W){1'b0}}, root_node} : '0;

  // Accept and queue items
  htd_front u_front (
    .clk   (clk),
    .rst   (rst),
    .items (items),
    .head  (head),
    .pop   (pop)
  );

  // Walk the tree and deliver results
  htd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .pop     (pop),
    .root    (root_node),
    .results (results)
  );

endmodule
